[rtl/core/drcm_pkg.sv]
`default_nettype none

package drcm_pkg;

    localparam int ADC_BITS        = 12;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int SCALE_W  = 24;
    localparam int THR_W    = 21;
    localparam int BLANK_W  = 16;
    localparam int SUM_W    = 58;
    localparam int CUR_W    = 27;
    localparam int MAG_W    = 26;
    localparam int DIFF_W   = ADC_BITS + 1;
    localparam int PROD_W   = DIFF_W + SCALE_W + 1;
    localparam int NA_W     = PROD_W - SCALE_FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam int CUR_LIMIT = 60000000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int S_TDATA_W = 2 * ADC_BITS;
    localparam int M_TDATA_RAW_W = CUR_W + 2 * MAG_W + 2 * ADC_BITS;
    localparam int M_TDATA_W = ((M_TDATA_RAW_W + 7) / 8) * 8;

    localparam logic [ADC_BITS-1:0] HIGH_OFFSET_RST = ADC_BITS'(2054);
    localparam logic [SCALE_W-1:0]  HIGH_SCALE_RST  = SCALE_W'(6778880);
    localparam logic [ADC_BITS-1:0] LOW_OFFSET_RST  = ADC_BITS'(2072);
    localparam logic [SCALE_W-1:0]  LOW_SCALE_RST   = SCALE_W'(144253);
    localparam logic [THR_W-1:0]    THRESHOLD_RST   = THR_W'(750000);
    localparam logic [BLANK_W-1:0]  BLANK_RST       = BLANK_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_OFFSET = 3'd0,
        CFG_HIGH_SCALE  = 3'd1,
        CFG_LOW_OFFSET  = 3'd2,
        CFG_LOW_SCALE   = 3'd3,
        CFG_THRESHOLD   = 3'd4,
        CFG_BLANK       = 3'd5
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SEL  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic sel;
        logic acc;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/dual_range_current_meter.sv]
// Channel   Direction  Payload (tdata / tuser, lowest bit first)
// s_        in         tdata: high_code[11:0], low_code[23:12]
// m_        out        tdata: current_na, average_na, peak_na, high_code_echo,
//                      low_code_echo, zero pad; tuser: high_range_used
// cfg_      in         cfg_index selects the register, cfg_data carries its value
//
// A request passes from acceptance to a loaded result through multiply, select
// and saturate, accumulate, 58 divider steps for the running mean, and the load.
// The next request is accepted once the previous result is loaded; its own result
// waits until m_tready has taken the one before it.
// Synchronous active-low reset restores register defaults and clears control
// state, sum, count, peak and blanking counter; data registers are not reset.

`default_nettype none

module dual_range_current_meter #(
    parameter int COUNT_BITS = drcm_pkg::COUNT_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // high_code, low_code
    input  wire [drcm_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // current_na, average_na, peak_na, high_code_echo, low_code_echo
    output logic [drcm_pkg::M_TDATA_W-1:0]    m_tdata,
    // high_range_used
    output logic                              m_tuser,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [drcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [drcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    drcm_pkg::dp_cmd_t    cmd;
    drcm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    drcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    drcm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/core/drcm_ctrl.sv]
`default_nettype none

module drcm_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output drcm_pkg::dp_cmd_t    cmd,
    input  drcm_pkg::dp_status_t status
);

    drcm_pkg::state_t state_reg;
    drcm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign s_tready = (state_reg == drcm_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            drcm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = drcm_pkg::ST_MUL;
                end
            end
            drcm_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = drcm_pkg::ST_SEL;
            end
            drcm_pkg::ST_SEL: begin
                cmd.sel    = 1'b1;
                state_next = drcm_pkg::ST_ACC;
            end
            drcm_pkg::ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = drcm_pkg::ST_DIV;
            end
            drcm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = drcm_pkg::ST_DONE;
                end
            end
            drcm_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = drcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = drcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= drcm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("More than one datapath command in a cycle.");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("Result loaded over an untaken result.");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == drcm_pkg::ST_MUL))
        else $error("Accepted request did not start the computation.");

endmodule

`default_nettype wire

[rtl/core/drcm_datapath.sv]
`default_nettype none

module drcm_datapath #(
    parameter int COUNT_BITS = drcm_pkg::COUNT_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire [drcm_pkg::S_TDATA_W-1:0]         s_tdata,
    input  wire                                   cfg_valid,
    input  wire [drcm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [drcm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  drcm_pkg::dp_cmd_t                     cmd,
    output drcm_pkg::dp_status_t                  status,
    output logic [drcm_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tuser
);

    localparam int AW = drcm_pkg::ADC_BITS;
    localparam int PW = drcm_pkg::PROD_W;
    localparam int NW = drcm_pkg::NA_W;
    localparam int SW = drcm_pkg::SUM_W;
    localparam int MW = drcm_pkg::MAG_W;
    localparam int CW = drcm_pkg::CUR_W;
    localparam logic signed [NW-1:0] LIMIT_POS = NW'(drcm_pkg::CUR_LIMIT);
    localparam logic signed [NW-1:0] LIMIT_NEG = -NW'(drcm_pkg::CUR_LIMIT);

    logic [AW-1:0]                high_offset_reg;
    logic [drcm_pkg::SCALE_W-1:0] high_scale_reg;
    logic [AW-1:0]                low_offset_reg;
    logic [drcm_pkg::SCALE_W-1:0] low_scale_reg;
    logic [drcm_pkg::THR_W-1:0]   threshold_reg;
    logic [drcm_pkg::BLANK_W-1:0] blank_samples_reg;

    logic [AW-1:0]           high_code_reg;
    logic [AW-1:0]           low_code_reg;
    logic signed [PW-1:0]    prod_high_reg;
    logic signed [PW-1:0]    prod_low_reg;
    logic signed [CW-1:0]    cur_reg;
    logic [MW-1:0]           mag_reg;
    logic                    use_high_reg;

    logic [SW-1:0]                sum_reg;
    logic [COUNT_BITS-1:0]        count_reg;
    logic [MW-1:0]                peak_reg;
    logic [drcm_pkg::BLANK_W-1:0] blank_cnt_reg;

    logic [SW-1:0]                   dvd_reg;
    logic [COUNT_BITS-1:0]           rem_reg;
    logic [drcm_pkg::DIV_CNT_W-1:0]  step_reg;

    logic signed [CW-1:0] cur_out_reg;
    logic [MW-1:0]        avg_out_reg;
    logic [MW-1:0]        peak_out_reg;
    logic                 range_out_reg;
    logic [AW-1:0]        high_echo_reg;
    logic [AW-1:0]        low_echo_reg;

    logic signed [drcm_pkg::DIFF_W-1:0] diff_high;
    logic signed [drcm_pkg::DIFF_W-1:0] diff_low;
    logic signed [PW-1:0]               shift_high;
    logic signed [PW-1:0]               shift_low;
    logic signed [NW-1:0]               na_high;
    logic signed [NW-1:0]               na_low;
    logic signed [NW-1:0]               na_sel;
    logic signed [NW-1:0]               na_sat;
    logic signed [NW-1:0]               na_abs;
    logic                               use_high;
    logic [SW:0]                        sum_add;
    logic                               acc_ok;
    logic [SW-1:0]                      sum_next;
    logic [COUNT_BITS:0]                trial;
    logic [COUNT_BITS:0]                trial_sub;
    logic                               trial_ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_offset_reg   <= drcm_pkg::HIGH_OFFSET_RST;
            high_scale_reg    <= drcm_pkg::HIGH_SCALE_RST;
            low_offset_reg    <= drcm_pkg::LOW_OFFSET_RST;
            low_scale_reg     <= drcm_pkg::LOW_SCALE_RST;
            threshold_reg     <= drcm_pkg::THRESHOLD_RST;
            blank_samples_reg <= drcm_pkg::BLANK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                drcm_pkg::CFG_HIGH_OFFSET: high_offset_reg <= cfg_data[AW-1:0];
                drcm_pkg::CFG_HIGH_SCALE:  high_scale_reg  <= cfg_data[drcm_pkg::SCALE_W-1:0];
                drcm_pkg::CFG_LOW_OFFSET:  low_offset_reg  <= cfg_data[AW-1:0];
                drcm_pkg::CFG_LOW_SCALE:   low_scale_reg   <= cfg_data[drcm_pkg::SCALE_W-1:0];
                drcm_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_data[drcm_pkg::THR_W-1:0];
                drcm_pkg::CFG_BLANK:
                    blank_samples_reg <= cfg_data[drcm_pkg::BLANK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign diff_high = $signed({1'b0, high_code_reg}) - $signed({1'b0, high_offset_reg});
    assign diff_low  = $signed({1'b0, low_code_reg}) - $signed({1'b0, low_offset_reg});

    assign shift_high = prod_high_reg >>> drcm_pkg::SCALE_FRAC_BITS;
    assign shift_low  = prod_low_reg >>> drcm_pkg::SCALE_FRAC_BITS;
    assign na_high    = shift_high[NW-1:0];
    assign na_low     = shift_low[NW-1:0];
    assign use_high   = na_low > $signed({{(NW - drcm_pkg::THR_W){1'b0}}, threshold_reg});
    assign na_sel     = use_high ? na_high : na_low;

    always_comb begin
        if (na_sel > LIMIT_POS) begin
            na_sat = LIMIT_POS;
        end else if (na_sel < LIMIT_NEG) begin
            na_sat = LIMIT_NEG;
        end else begin
            na_sat = na_sel;
        end
        na_abs = na_sat[NW-1] ? -na_sat : na_sat;
    end

    assign sum_add  = {1'b0, sum_reg} + {{(SW + 1 - MW){1'b0}}, mag_reg};
    assign acc_ok   = (count_reg != {COUNT_BITS{1'b1}}) && !sum_add[SW];
    assign sum_next = acc_ok ? sum_add[SW-1:0] : sum_reg;

    assign trial     = {rem_reg, dvd_reg[SW-1]};
    assign trial_sub = trial - {1'b0, count_reg};
    assign trial_ge  = trial >= {1'b0, count_reg};

    assign status.div_last = (step_reg == drcm_pkg::DIV_CNT_W'(SW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            blank_cnt_reg <= '0;
            step_reg      <= '0;
        end else begin
            if (cmd.acc) begin
                sum_reg  <= sum_next;
                step_reg <= '0;
                if (acc_ok) begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
                if (blank_cnt_reg < blank_samples_reg) begin
                    blank_cnt_reg <= blank_cnt_reg + drcm_pkg::BLANK_W'(1);
                end else if (mag_reg > peak_reg) begin
                    peak_reg <= mag_reg;
                end
            end
            if (cmd.div_step) begin
                step_reg <= step_reg + drcm_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            high_code_reg <= s_tdata[AW-1:0];
            low_code_reg  <= s_tdata[2*AW-1:AW];
        end
        if (cmd.mul) begin
            prod_high_reg <= PW'(diff_high * $signed({1'b0, high_scale_reg}));
            prod_low_reg  <= PW'(diff_low * $signed({1'b0, low_scale_reg}));
        end
        if (cmd.sel) begin
            cur_reg      <= na_sat[CW-1:0];
            mag_reg      <= na_abs[MW-1:0];
            use_high_reg <= use_high;
        end
        if (cmd.acc) begin
            dvd_reg <= sum_next;
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            dvd_reg <= {dvd_reg[SW-2:0], trial_ge};
        end
        if (cmd.load_out) begin
            cur_out_reg   <= cur_reg;
            avg_out_reg   <= (count_reg == '0) ? '0 : dvd_reg[MW-1:0];
            peak_out_reg  <= peak_reg;
            range_out_reg <= use_high_reg;
            high_echo_reg <= high_code_reg;
            low_echo_reg  <= low_code_reg;
        end
    end

    assign m_tdata = {{(drcm_pkg::M_TDATA_W - drcm_pkg::M_TDATA_RAW_W){1'b0}},
                      low_echo_reg, high_echo_reg, peak_out_reg, avg_out_reg, cur_out_reg};
    assign m_tuser = range_out_reg;

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= $past(count_reg))
        else $error("Sample count went down.");

    a_sum_held_without_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.acc) |-> $stable(sum_reg))
        else $error("Magnitude sum changed outside accumulation.");

    a_peak_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg <= MW'(drcm_pkg::CUR_LIMIT))
        else $error("Peak magnitude above the current limit.");

    a_count_with_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("Nonzero sum with zero sample count.");

endmodule

`default_nettype wire
